### sv/us2cal_pkg.sv
`default_nettype none
package us2cal_pkg;

   localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
   localparam logic [11:0] LAST_YEAR    = 12'd2099;
   localparam logic [11:0] CENTURY_YEAR = 12'd2100;
   localparam logic [8:0]  YEAR_DAYS    = 9'd365;
   localparam logic [3:0]  LAST_MONTH   = 4'd12;
   localparam logic [3:0]  FEBRUARY     = 4'd2;
   // 1970-01-01 was a Thursday; offset so that (days + 3) mod 7 = 0 is Monday
   localparam logic [15:0] WEEKDAY_BIAS = 16'd3;
   // final cycle of a divider pass
   localparam logic        DIV_LAST     = 1'b1;

   // divider passes, in the order they run
   typedef enum logic [1:0] {
      DIV_SEC  = 2'd0,
      DIV_MIN  = 2'd1,
      DIV_HOUR = 2'd2,
      DIV_WDAY = 2'd3
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_step;
      div_sel_type div_sel;
      logic        div_last;
      logic        year_step;
      logic        month_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic year_fits;
      logic month_fits;
   } status_type;

   function automatic logic [5:0] div_const(input div_sel_type sel);
      logic [5:0] d;
      unique case (sel)
         DIV_SEC:  d = 6'd60;
         DIV_MIN:  d = 6'd60;
         DIV_HOUR: d = 6'd24;
         DIV_WDAY: d = 6'd7;
         default:  d = 6'd60;
      endcase
      return d;
   endfunction

   // scaled reciprocals: ceil(2^37/60) and ceil(2^36/24) hold for any 32-bit
   // dividend, ceil(2^19/7) for the 16-bit day count
   function automatic logic [31:0] recip_const(input div_sel_type sel);
      logic [31:0] r;
      unique case (sel)
         DIV_SEC:  r = 32'h8888_8889;
         DIV_MIN:  r = 32'h8888_8889;
         DIV_HOUR: r = 32'hAAAA_AAAB;
         DIV_WDAY: r = 32'd74899;
         default:  r = 32'h8888_8889;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd2:                      len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

### sv/us2cal_ctrl.sv
`default_nettype none
module us2cal_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  us2cal_pkg::status_type status,
   output us2cal_pkg::cmd_type    cmd
);
   import us2cal_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_YEAR  = 5'b00100,
      ST_MONTH = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   div_sel_type phase_ff, phase_in;
   logic        count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      cmd          = '0;
      cmd.div_sel  = phase_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               phase_in = DIV_SEC;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_last = (count_ff == DIV_LAST);
            if (count_ff == DIV_LAST) begin
               count_in = '0;
               if (phase_ff == DIV_WDAY) begin
                  state_in = ST_YEAR;
               end else begin
                  phase_in = div_sel_type'(phase_ff + 2'd1);
               end
            end else begin
               count_in = 1'b1;
            end
         end
         ST_YEAR: begin
            if (status.year_fits) begin
               state_in = ST_MONTH;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_MONTH: begin
            if (status.month_fits) begin
               state_in = ST_DONE;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         ST_DONE: begin
            // hand over only once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= DIV_SEC;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### sv/us2cal_dp.sv
`default_nettype none
module us2cal_dp (
   input  wire                    clock,
   input  wire [31:0]             req_unix_seconds,
   input  us2cal_pkg::cmd_type    cmd,
   output us2cal_pkg::status_type status,
   output logic [11:0]            rsp_year,
   output logic [3:0]             rsp_month,
   output logic [4:0]             rsp_day_of_month,
   output logic [2:0]             rsp_weekday,
   output logic [4:0]             rsp_hour,
   output logic [5:0]             rsp_minute,
   output logic [5:0]             rsp_second,
   output logic                   rsp_year_clamped
);
   import us2cal_pkg::*;

   logic [31:0] dvd_ff, dvd_in;
   logic [63:0] prod_ff;
   logic [5:0]  sec_ff, min_ff;
   logic [4:0]  hr_ff;
   logic [2:0]  wd_ff;
   logic [15:0] days_ff, days_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;

   logic [11:0] year_ff_out;
   logic [3:0]  month_ff_out;
   logic [4:0]  day_ff_out, hr_ff_out;
   logic [2:0]  wd_ff_out;
   logic [5:0]  min_ff_out, sec_ff_out;
   logic        clamped_ff_out;

   logic [5:0]  divisor;
   logic [31:0] recip;
   logic [5:0]  rem_next;
   logic [31:0] quot_next;
   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;

   // multiply by the scaled reciprocal and register the product, then take
   // quotient and remainder from the registered product in the final cycle of the pass
   always_comb begin
      divisor = div_const(cmd.div_sel);
      recip   = recip_const(cmd.div_sel);
      unique case (cmd.div_sel)
         DIV_SEC, DIV_MIN: quot_next = {5'd0, prod_ff[63:37]};
         DIV_HOUR:         quot_next = {4'd0, prod_ff[63:36]};
         DIV_WDAY:         quot_next = {13'd0, prod_ff[37:19]};
         default:          quot_next = {5'd0, prod_ff[63:37]};
      endcase
      // the remainder is below 64, so the low six bits of the difference hold it
      rem_next = dvd_ff[5:0] - 6'(quot_next[5:0] * divisor);
   end

   always_comb begin
      leap = (year_ff[1:0] == 2'b00) && (year_ff != CENTURY_YEAR);
      ylen = leap ? 9'(YEAR_DAYS + 9'd1) : YEAR_DAYS;
      mlen = month_len(month_ff) + 5'((leap && month_ff == FEBRUARY) ? 1 : 0);
      status.year_fits  = (days_ff < {7'd0, ylen});
      status.month_fits = (days_ff < {11'd0, mlen}) || (month_ff >= LAST_MONTH);
   end

   always_comb begin
      dvd_in   = dvd_ff;
      days_in  = days_ff;
      year_in  = year_ff;
      month_in = month_ff;
      if (cmd.load) begin
         dvd_in   = req_unix_seconds;
         year_in  = EPOCH_YEAR;
         month_in = 4'd1;
      end else if (cmd.div_step) begin
         if (cmd.div_last) begin
            dvd_in = quot_next;
            if (cmd.div_sel == DIV_HOUR) begin
               days_in = quot_next[15:0];
               dvd_in  = {16'd0, quot_next[15:0] + WEEKDAY_BIAS};
            end
         end
      end else if (cmd.year_step) begin
         days_in = days_ff - {7'd0, ylen};
         year_in = year_ff + 12'd1;
      end else if (cmd.month_step) begin
         days_in  = days_ff - {11'd0, mlen};
         month_in = month_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      if (cmd.div_step && !cmd.div_last) begin
         prod_ff <= 64'(dvd_ff) * 64'(recip);
      end
      if (cmd.div_step && cmd.div_last) begin
         unique case (cmd.div_sel)
            DIV_SEC:  sec_ff <= rem_next;
            DIV_MIN:  min_ff <= rem_next;
            DIV_HOUR: hr_ff  <= rem_next[4:0];
            DIV_WDAY: wd_ff  <= rem_next[2:0] + 3'd1;
            default:  sec_ff <= rem_next;
         endcase
      end
      if (cmd.out_load) begin
         clamped_ff_out <= (year_ff > LAST_YEAR);
         year_ff_out    <= (year_ff > LAST_YEAR) ? LAST_YEAR : year_ff;
         month_ff_out   <= month_ff;
         day_ff_out     <= days_ff[4:0] + 5'd1;
         wd_ff_out      <= wd_ff;
         hr_ff_out      <= hr_ff;
         min_ff_out     <= min_ff;
         sec_ff_out     <= sec_ff;
      end
   end

   assign rsp_year         = year_ff_out;
   assign rsp_month        = month_ff_out;
   assign rsp_day_of_month = day_ff_out;
   assign rsp_weekday      = wd_ff_out;
   assign rsp_hour         = hr_ff_out;
   assign rsp_minute       = min_ff_out;
   assign rsp_second       = sec_ff_out;
   assign rsp_year_clamped = clamped_ff_out;

endmodule
`default_nettype wire

### sv/unix_seconds_to_calendar_top.sv
// Unix seconds to calendar date and time of day.
// Input channel (req_): one beat carries a 32-bit count of seconds since
// 1970-01-01 00:00:00. Result channel (rsp_): one beat per input with year,
// month, day of month, weekday (1 Monday .. 7 Sunday), hour, minute, second
// and a flag set when the year passed 2099 and reads as 2099.
// Steps: accept, then passes of the shared constant divider (seconds,
// minutes, hours, then day count mod 7; each pass multiplies by a scaled
// reciprocal, then takes quotient and remainder), a year walk that subtracts
// one year length per step, a month walk that subtracts one month length per
// step, and a hand-over to the output register. A new beat is taken only
// after the result has been handed over; one item is in work at a time.
// req_ready is high whenever the engine is idle, even while a finished
// result still waits in the output register; a stalled receiver holds the
// result there and the next conversion waits in its final step.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any pending result beat.
`default_nettype none
module unix_seconds_to_calendar_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_unix_seconds,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [2:0]  rsp_weekday,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic        rsp_year_clamped
);
   import us2cal_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: divider passes, year walk, month walk, hand-over
   us2cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // working registers and the output register
   us2cal_dp u_dp (
      .clock            (clock),
      .req_unix_seconds (req_unix_seconds),
      .cmd              (cmd),
      .status           (status),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_weekday      (rsp_weekday),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_year_clamped (rsp_year_clamped)
   );

endmodule
`default_nettype wire
